/* src/lcd_mux_segment_dc_monitor_assert.svh */
// Assertion macros used by the checker module of the LCD DC-balance monitor.
// Each macro expects i_clk, and LMDC_ASSERT also i_rst_n, to exist in the scope where it is used.
`ifndef LCD_MUX_SEGMENT_DC_MONITOR_ASSERT_SVH
`define LCD_MUX_SEGMENT_DC_MONITOR_ASSERT_SVH

// Checked only while the block is out of reset.
`define LMDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LMDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/lmdc_pkg.sv */
`default_nettype none

package lmdc_pkg;

    localparam int NUM_EL          = 7;
    localparam int NUM_COM         = 4;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int LEVEL_W         = 10;
    localparam int DC_W            = 11;
    localparam int MUX_W           = 2;
    localparam int PHASE_W         = 3;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;
    localparam int Q_DEPTH         = 2;
    localparam int SEG_IDX_W       = $clog2(NUM_EL);
    localparam int COM_IDX_W       = $clog2(NUM_COM);

    localparam logic [DC_W-1:0] DC_LIMIT_RESET = 11'd41;

    localparam logic [MUX_W-1:0] CFG_MUX_LEVEL = 2'd0;
    localparam logic [MUX_W-1:0] CFG_TYPE_B    = 2'd1;
    localparam logic [MUX_W-1:0] CFG_DC_LIMIT  = 2'd2;

    // Segment pin and common pin of each element a..g, per multiplex level.
    localparam logic [SEG_IDX_W-1:0] PIN_SEG [NUM_COM][NUM_EL] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6},
        '{3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd1},
        '{3'd1, 3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd1},
        '{3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd0}
    };

    localparam logic [COM_IDX_W-1:0] PIN_COM [NUM_COM][NUM_EL] = '{
        '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1},
        '{2'd2, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd1},
        '{2'd3, 2'd3, 2'd1, 2'd0, 2'd1, 2'd2, 2'd2}
    };

    typedef struct packed {
        logic [NUM_EL-1:0] act;
        logic              first;
        logic              last;
    } t_ctl;

endpackage

`default_nettype wire

/* src/lmdc_front.sv */
`default_nettype none

module lmdc_front #(
    parameter int SAMPLE_BITS = lmdc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [lmdc_pkg::MUX_W-1:0]    i_mux_level,
    input  wire logic                          i_type_b,
    input  wire logic                          i_restart,
    input  wire logic                          i_push,
    input  wire logic [SAMPLE_BITS-1:0]        i_seg [lmdc_pkg::NUM_EL],
    input  wire logic [SAMPLE_BITS-1:0]        i_com [lmdc_pkg::NUM_COM],
    output lmdc_pkg::t_ctl                     o_ctl,
    output logic [lmdc_pkg::NUM_EL*(SAMPLE_BITS+1)-1:0] o_diff
);
    import lmdc_pkg::*;

    localparam int DW = SAMPLE_BITS + 1;

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] commons;
    logic [PHASE_W-1:0] slot;
    logic [PHASE_W-1:0] rem;
    logic               mode_b;
    logic               last;

    always_comb begin
        commons = PHASE_W'(i_mux_level) + PHASE_W'(1);
        mode_b  = i_type_b && (i_mux_level != '0);
        rem     = r_phase;
        for (int k = 0; k < 3; k++) begin
            if (rem >= commons) begin
                rem = rem - commons;
            end
        end
        if (mode_b) begin
            slot        = rem;
            o_ctl.first = r_phase < commons;
        end else begin
            slot        = r_phase >> 1;
            o_ctl.first = !r_phase[0];
        end
        last       = ({1'b0, r_phase} + 4'd1) >= {commons, 1'b0};
        o_ctl.last = last;
        for (int i = 0; i < NUM_EL; i++) begin
            o_ctl.act[i]       = PHASE_W'(PIN_COM[i_mux_level][i]) == slot;
            o_diff[i*DW +: DW] = DW'(i_com[PIN_COM[i_mux_level][i]])
                               - DW'(i_seg[PIN_SEG[i_mux_level][i]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_restart) begin
            r_phase <= '0;
        end else if (i_push) begin
            r_phase <= last ? '0 : r_phase + PHASE_W'(1);
        end
    end

endmodule

`default_nettype wire

/* src/lmdc_queue.sv */
`default_nettype none

module lmdc_queue #(
    parameter int WIDTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);
    import lmdc_pkg::*;

    // Pointers wrap naturally, so the depth is a power of two.
    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = r_cnt == CW'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* src/lmdc_back.sv */
`default_nettype none

module lmdc_back #(
    parameter int SAMPLE_BITS = lmdc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [lmdc_pkg::DC_W-1:0]     i_dc_limit,
    input  wire logic                          i_q_valid,
    input  wire lmdc_pkg::t_ctl                i_ctl,
    input  wire logic [lmdc_pkg::NUM_EL*(SAMPLE_BITS+1)-1:0] i_diff,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [SAMPLE_BITS-1:0]             o_level [lmdc_pkg::NUM_EL],
    output logic [lmdc_pkg::NUM_EL-1:0]        o_fault_mask,
    output logic                               o_frame_end,
    output logic [SAMPLE_BITS-1:0]             o_frame_max
);
    import lmdc_pkg::*;

    localparam int DW = SAMPLE_BITS + 1;
    localparam int CW = SAMPLE_BITS + 4;

    logic signed [DW-1:0]      r_first [NUM_EL];
    logic [SAMPLE_BITS-1:0]    r_level [NUM_EL];
    logic [SAMPLE_BITS-1:0]    r_run;
    logic [SAMPLE_BITS-1:0]    r_done;
    logic                      r_valid;
    logic [NUM_EL-1:0]         r_fault;
    logic                      r_frame_end;

    logic signed [DW-1:0]      diff [NUM_EL];
    logic signed [DW-1:0]      absval [NUM_EL];
    logic signed [CW-1:0]      pair_sum [NUM_EL];
    logic signed [CW-1:0]      limit;
    logic [NUM_EL-1:0]         second;
    logic [NUM_EL-1:0]         n_fault;
    logic [SAMPLE_BITS-1:0]    n_level [NUM_EL];
    logic [SAMPLE_BITS-1:0]    n_max;

    always_comb begin
        o_pop = i_q_valid && (!r_valid || i_ready);
        limit = signed'(CW'(i_dc_limit));
        n_max = r_run;
        for (int i = 0; i < NUM_EL; i++) begin
            diff[i]     = signed'(i_diff[i*DW +: DW]);
            second[i]   = i_ctl.act[i] && !i_ctl.first;
            pair_sum[i] = CW'(r_first[i]) + CW'(diff[i]);
            absval[i]   = r_first[i][DW-1] ? -r_first[i] : r_first[i];
            n_fault[i]  = second[i] && (pair_sum[i] > limit);
            n_level[i]  = second[i] ? absval[i][SAMPLE_BITS-1:0] : r_level[i];
            if (second[i] && (absval[i][SAMPLE_BITS-1:0] > n_max)) begin
                n_max = absval[i][SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_fault     <= '0;
            r_frame_end <= 1'b0;
            r_run       <= '0;
            r_done      <= '0;
            for (int i = 0; i < NUM_EL; i++) begin
                r_first[i] <= '0;
                r_level[i] <= '0;
            end
        end else if (o_pop) begin
            r_valid     <= 1'b1;
            r_fault     <= n_fault;
            r_frame_end <= i_ctl.last;
            if (i_ctl.last) begin
                r_done <= n_max;
                r_run  <= '0;
            end else begin
                r_run <= n_max;
            end
            for (int i = 0; i < NUM_EL; i++) begin
                r_level[i] <= n_level[i];
                if (i_ctl.act[i] && i_ctl.first) begin
                    r_first[i] <= diff[i];
                end
            end
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid      = r_valid;
    assign o_level      = r_level;
    assign o_fault_mask = r_fault;
    assign o_frame_end  = r_frame_end;
    assign o_frame_max  = r_done;

endmodule

`default_nettype wire

/* src/lcd_mux_segment_dc_monitor.sv */
// DC-balance monitor for a multiplexed seven-segment LCD drive.
// Input channel (i_in_valid / o_in_ready): one item per drive phase, carrying
// the sampled codes of segment pins 0..6 and common pins 0..3.
// Output channel (o_out_valid / i_out_ready): one result per item, in order,
// with the element levels a..g after that phase, the mask of elements that
// failed the DC check, a frame end flag and the maximum of the last frame.
// Configuration goes through the APB-style port: mux level at 0x0, type B
// ordering at 0x4, DC limit at 0x8. A change of mux level restarts the phase.
// A front stage takes an item in the cycle it is offered while the queue has
// room, works out its common slot and phase half, and pushes it into a
// two-entry queue; the back stage pops it when its output is free and registers
// the result. One item per cycle is sustained while the receiver takes results,
// limited only by the single back stage that updates the element state.
// When the receiver stalls, the result holds and the queue fills; the input
// is held off only once both queue entries are taken.
// Synchronous reset clears the phase counter, the stored voltages, levels and
// maxima, and sets the registers to static drive, type A and a limit of 41.
`default_nettype none

module lcd_mux_segment_dc_monitor #(
    parameter int SAMPLE_BITS = lmdc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0]        i_seg_0,
    input  wire logic [SAMPLE_BITS-1:0]        i_seg_1,
    input  wire logic [SAMPLE_BITS-1:0]        i_seg_2,
    input  wire logic [SAMPLE_BITS-1:0]        i_seg_3,
    input  wire logic [SAMPLE_BITS-1:0]        i_seg_4,
    input  wire logic [SAMPLE_BITS-1:0]        i_seg_5,
    input  wire logic [SAMPLE_BITS-1:0]        i_seg_6,
    input  wire logic [SAMPLE_BITS-1:0]        i_com_0,
    input  wire logic [SAMPLE_BITS-1:0]        i_com_1,
    input  wire logic [SAMPLE_BITS-1:0]        i_com_2,
    input  wire logic [SAMPLE_BITS-1:0]        i_com_3,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [lmdc_pkg::LEVEL_W-1:0]       o_level_a,
    output logic [lmdc_pkg::LEVEL_W-1:0]       o_level_b,
    output logic [lmdc_pkg::LEVEL_W-1:0]       o_level_c,
    output logic [lmdc_pkg::LEVEL_W-1:0]       o_level_d,
    output logic [lmdc_pkg::LEVEL_W-1:0]       o_level_e,
    output logic [lmdc_pkg::LEVEL_W-1:0]       o_level_f,
    output logic [lmdc_pkg::LEVEL_W-1:0]       o_level_g,
    output logic [lmdc_pkg::NUM_EL-1:0]        o_fault_mask,
    output logic                               o_frame_end,
    output logic [lmdc_pkg::LEVEL_W-1:0]       o_frame_max,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lmdc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lmdc_pkg::DATA_W-1:0]   pwdata,
    output logic [lmdc_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import lmdc_pkg::*;

    localparam int DW = SAMPLE_BITS + 1;
    localparam int QW = $bits(t_ctl) + NUM_EL * DW;

    logic [MUX_W-1:0]           r_mux_level;
    logic                       r_type_b;
    logic [DC_W-1:0]            r_dc_limit;

    logic                       cfg_wr;
    logic [MUX_W-1:0]           cfg_idx;
    logic                       restart;
    logic                       push;
    logic                       q_full;
    logic                       q_valid;
    logic                       pop;
    logic [QW-1:0]              q_wdata;
    logic [QW-1:0]              q_rdata;
    t_ctl                       f_ctl;
    t_ctl                       b_ctl;
    logic [NUM_EL*DW-1:0]       f_diff;
    logic [NUM_EL*DW-1:0]       b_diff;
    logic [SAMPLE_BITS-1:0]     seg [NUM_EL];
    logic [SAMPLE_BITS-1:0]     com [NUM_COM];
    logic [SAMPLE_BITS-1:0]     level [NUM_EL];
    logic [SAMPLE_BITS-1:0]     frame_max;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign restart = cfg_wr && (cfg_idx == CFG_MUX_LEVEL)
                   && (pwdata[MUX_W-1:0] != r_mux_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mux_level <= '0;
            r_type_b    <= 1'b0;
            r_dc_limit  <= DC_LIMIT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_MUX_LEVEL: r_mux_level <= pwdata[MUX_W-1:0];
                CFG_TYPE_B:    r_type_b    <= pwdata[0];
                CFG_DC_LIMIT:  r_dc_limit  <= pwdata[DC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_MUX_LEVEL: prdata = DATA_W'(r_mux_level);
            CFG_TYPE_B:    prdata = DATA_W'(r_type_b);
            CFG_DC_LIMIT:  prdata = DATA_W'(r_dc_limit);
            default:       prdata = '0;
        endcase
    end

    assign seg = '{i_seg_0, i_seg_1, i_seg_2, i_seg_3, i_seg_4, i_seg_5, i_seg_6};
    assign com = '{i_com_0, i_com_1, i_com_2, i_com_3};

    assign o_in_ready = !q_full;
    assign push       = i_in_valid && !q_full;

    lmdc_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mux_level (r_mux_level),
        .i_type_b    (r_type_b),
        .i_restart   (restart),
        .i_push      (push),
        .i_seg       (seg),
        .i_com       (com),
        .o_ctl       (f_ctl),
        .o_diff      (f_diff)
    );

    assign q_wdata         = {f_ctl, f_diff};
    assign {b_ctl, b_diff} = q_rdata;

    lmdc_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    lmdc_back #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dc_limit   (r_dc_limit),
        .i_q_valid    (q_valid),
        .i_ctl        (b_ctl),
        .i_diff       (b_diff),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_level      (level),
        .o_fault_mask (o_fault_mask),
        .o_frame_end  (o_frame_end),
        .o_frame_max  (frame_max)
    );

    assign o_level_a   = LEVEL_W'(level[0]);
    assign o_level_b   = LEVEL_W'(level[1]);
    assign o_level_c   = LEVEL_W'(level[2]);
    assign o_level_d   = LEVEL_W'(level[3]);
    assign o_level_e   = LEVEL_W'(level[4]);
    assign o_level_f   = LEVEL_W'(level[5]);
    assign o_level_g   = LEVEL_W'(level[6]);
    assign o_frame_max = LEVEL_W'(frame_max);

endmodule

`default_nettype wire

/* src/lmdc_checker.sv */
`default_nettype none
`include "lcd_mux_segment_dc_monitor_assert.svh"

module lmdc_checker #(
    parameter int SAMPLE_BITS = lmdc_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic [SAMPLE_BITS-1:0]        i_seg_0,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [lmdc_pkg::LEVEL_W-1:0]  o_level_a,
    input wire logic [lmdc_pkg::NUM_EL-1:0]   o_fault_mask,
    input wire logic                          o_frame_end,
    input wire logic [lmdc_pkg::LEVEL_W-1:0]  o_frame_max,
    input wire logic                          psel,
    input wire logic                          penable,
    input wire logic                          pwrite,
    input wire logic [lmdc_pkg::ADDR_W-1:0]   paddr,
    input wire logic [lmdc_pkg::DATA_W-1:0]   pwdata,
    input wire logic [lmdc_pkg::DATA_W-1:0]   prdata
);
    import lmdc_pkg::*;

    logic dc_wr;
    logic dc_rd;

    assign dc_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == CFG_DC_LIMIT);
    assign dc_rd = psel && !pwrite && (paddr[ADDR_W-1:2] == CFG_DC_LIMIT);

    // A stalled result keeps its payload.
    `LMDC_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_level_a) && $stable(o_fault_mask) && $stable(o_frame_end) && $stable(o_frame_max), "stalled result changed")

    // The frame maximum only moves with a result that closes a frame.
    `LMDC_ASSERT(a_frame_max_hold, $past(o_out_valid && i_out_ready) && o_out_valid && !o_frame_end |-> o_frame_max == $past(o_frame_max), "frame maximum changed inside a frame")

    // A DC limit write reads back on the following cycle.
    `LMDC_ASSERT(a_dc_readback, $past(i_rst_n) && $past(dc_wr) && dc_rd |-> prdata[DC_W-1:0] == $past(pwdata[DC_W-1:0]), "DC limit readback mismatch")

    // An offered item waits unchanged until it is taken.
    `LMDC_ASSERT(a_in_hold, i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_seg_0), "input item dropped")

    // Reset leaves no result pending.
    `LMDC_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind lcd_mux_segment_dc_monitor lmdc_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_lmdc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_seg_0      (i_seg_0),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_level_a    (o_level_a),
    .o_fault_mask (o_fault_mask),
    .o_frame_end  (o_frame_end),
    .o_frame_max  (o_frame_max),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);

`default_nettype wire
